### src/touch_panel_response_decoder_assert.svh
// assertion macros for the touch panel response decoder
// used by the top level only; needs a clock named i_clk and a reset named i_rst_n
`ifndef TOUCH_PANEL_RESPONSE_DECODER_ASSERT_SVH
`define TOUCH_PANEL_RESPONSE_DECODER_ASSERT_SVH

`ifndef SYNTH
`define TPRD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("tprd assertion failed");
`define TPRD_ASSERT_NEXT(lbl, pre, post) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("tprd assertion failed");
`else
`define TPRD_ASSERT(lbl, prop)
`define TPRD_ASSERT_NEXT(lbl, pre, post)
`endif

`endif

### src/tprd_pkg.sv
// shared types and constants of the touch panel response decoder
// no dependencies
`default_nettype none

package tprd_pkg;

    localparam int BUFFER_DEPTH = 16;
    localparam int STORE_IDX_W  = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W      = 6;
    localparam int FIELD_BYTES  = 6;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 6'd63;
    localparam logic [7:0]         TERM_BYTE = 8'hFF;
    localparam logic [1:0]         TERM_RUN  = 2'd3;

    localparam logic [7:0]  RST_BUTTON_CODE   = 8'd101;
    localparam logic [4:0]  RST_BUTTON_LENGTH = 5'd7;
    localparam logic [7:0]  RST_COORD_CODE    = 8'd103;
    localparam logic [4:0]  RST_COORD_LENGTH  = 5'd9;
    localparam logic [7:0]  RST_UPDATE_CODE   = 8'd113;
    localparam logic [4:0]  RST_UPDATE_LENGTH = 5'd8;
    localparam logic [15:0] RST_POLL_PERIOD   = 16'd5;

    localparam logic       CMD_BYTE = 1'b0;
    localparam logic       CMD_TICK = 1'b1;

    localparam logic [2:0] EV_NONE   = 3'd0;
    localparam logic [2:0] EV_BUTTON = 3'd1;
    localparam logic [2:0] EV_COORD  = 3'd2;
    localparam logic [2:0] EV_REQ_X  = 3'd3;
    localparam logic [2:0] EV_REQ_Y  = 3'd4;

    localparam logic [1:0] PRESS_NONE    = 2'd0;
    localparam logic [1:0] PRESS_INITIAL = 2'd1;
    localparam logic [1:0] PRESS_HOLD    = 2'd2;

    typedef enum logic [2:0] {
        CFG_BUTTON_CODE   = 3'd0,
        CFG_BUTTON_LENGTH = 3'd1,
        CFG_COORD_CODE    = 3'd2,
        CFG_COORD_LENGTH  = 3'd3,
        CFG_UPDATE_CODE   = 3'd4,
        CFG_UPDATE_LENGTH = 3'd5,
        CFG_POLL_PERIOD   = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_REQ_X  = 2'd0,
        PH_X_SENT = 2'd1,
        PH_REQ_Y  = 2'd2,
        PH_Y_SENT = 2'd3
    } t_poll_phase;

    typedef struct packed {
        logic [7:0]  button_code;
        logic [4:0]  button_length;
        logic [7:0]  coord_code;
        logic [4:0]  coord_length;
        logic [7:0]  update_code;
        logic [4:0]  update_length;
        logic [15:0] poll_period_ms;
    } t_cfg;

    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [7:0]  button_state;
        logic [7:0]  button_number;
        logic [15:0] x_pos;
        logic [15:0] y_pos;
        logic [1:0]  press_type;
    } t_out_item;

    typedef struct packed {
        logic                          done;
        logic [COUNT_W-1:0]            count;
        logic [FIELD_BYTES-1:0][7:0]   bytes;
    } t_frame_info;

endpackage

`default_nettype wire

### src/tprd_cfg_regs.sv
// configuration registers of the touch panel response decoder
// depends on tprd_pkg
`default_nettype none

module tprd_cfg_regs (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_cfg_wr_en,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [15:0]   i_cfg_data,
    output tprd_pkg::t_cfg     o_cfg
);

    tprd_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.button_code    <= tprd_pkg::RST_BUTTON_CODE;
            r_cfg.button_length  <= tprd_pkg::RST_BUTTON_LENGTH;
            r_cfg.coord_code     <= tprd_pkg::RST_COORD_CODE;
            r_cfg.coord_length   <= tprd_pkg::RST_COORD_LENGTH;
            r_cfg.update_code    <= tprd_pkg::RST_UPDATE_CODE;
            r_cfg.update_length  <= tprd_pkg::RST_UPDATE_LENGTH;
            r_cfg.poll_period_ms <= tprd_pkg::RST_POLL_PERIOD;
        end else if (i_cfg_wr_en) begin
            case (tprd_pkg::t_cfg_index'(i_cfg_index))
                tprd_pkg::CFG_BUTTON_CODE:   r_cfg.button_code    <= i_cfg_data[7:0];
                tprd_pkg::CFG_BUTTON_LENGTH: r_cfg.button_length  <= i_cfg_data[4:0];
                tprd_pkg::CFG_COORD_CODE:    r_cfg.coord_code     <= i_cfg_data[7:0];
                tprd_pkg::CFG_COORD_LENGTH:  r_cfg.coord_length   <= i_cfg_data[4:0];
                tprd_pkg::CFG_UPDATE_CODE:   r_cfg.update_code    <= i_cfg_data[7:0];
                tprd_pkg::CFG_UPDATE_LENGTH: r_cfg.update_length  <= i_cfg_data[4:0];
                tprd_pkg::CFG_POLL_PERIOD:   r_cfg.poll_period_ms <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

### src/tprd_frame_buf.sv
// frame store, byte count and terminator detection
// depends on tprd_pkg
`default_nettype none

module tprd_frame_buf (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  tprd_pkg::t_in_item        i_item,
    output tprd_pkg::t_frame_info     o_frame
);

    logic [7:0]                      r_store [tprd_pkg::BUFFER_DEPTH];
    logic [tprd_pkg::COUNT_W-1:0]    r_count;
    logic [1:0]                      r_run;
    logic [tprd_pkg::COUNT_W-1:0]    n_count;
    logic [1:0]                      n_run;
    logic [tprd_pkg::COUNT_W-1:0]    count_inc;
    logic [1:0]                      run_inc;
    logic                            is_byte;
    logic                            wr_en;
    logic [tprd_pkg::STORE_IDX_W-1:0] wr_idx;

    assign is_byte = (i_item.command == tprd_pkg::CMD_BYTE);
    assign wr_en   = is_byte && (int'(r_count) < tprd_pkg::BUFFER_DEPTH);
    assign wr_idx  = r_count[tprd_pkg::STORE_IDX_W-1:0];

    always_comb begin
        count_inc = (r_count < tprd_pkg::COUNT_MAX) ? r_count + 1'b1 : r_count;
        run_inc   = (i_item.rx_byte == tprd_pkg::TERM_BYTE) ? r_run + 1'b1 : 2'd0;
        o_frame.done  = is_byte && (run_inc == tprd_pkg::TERM_RUN);
        o_frame.count = count_inc;
        for (int i = 0; i < tprd_pkg::FIELD_BYTES; i++) begin
            // the byte being written this cycle is visible to the decode
            o_frame.bytes[i] = (wr_en && int'(wr_idx) == i) ? i_item.rx_byte : r_store[i];
        end
        n_count = r_count;
        n_run   = r_run;
        if (is_byte) begin
            if (o_frame.done) begin
                n_count = '0;
                n_run   = 2'd0;
            end else begin
                n_count = count_inc;
                n_run   = run_inc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance && wr_en) begin
            r_store[wr_idx] <= i_item.rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_run   <= 2'd0;
        end else if (i_advance) begin
            r_count <= n_count;
            r_run   <= n_run;
        end
    end

endmodule

`default_nettype wire

### src/tprd_event_dec.sv
// frame matching, press state and poll timing
// depends on tprd_pkg
`default_nettype none

module tprd_event_dec (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_advance,
    input  tprd_pkg::t_in_item        i_item,
    input  tprd_pkg::t_frame_info     i_frame,
    input  tprd_pkg::t_cfg            i_cfg,
    output tprd_pkg::t_out_item       o_result
);

    logic                  r_pressed;
    tprd_pkg::t_poll_phase r_phase;
    logic [15:0]           r_x_latch;
    logic [15:0]           r_ms;
    logic                  n_pressed;
    tprd_pkg::t_poll_phase n_phase;
    logic [15:0]           n_x_latch;
    logic [15:0]           n_ms;
    logic [15:0]           ms_inc;
    logic [15:0]           upd_value;
    logic                  fits;
    logic                  hit_button;
    logic                  hit_coord;
    logic                  hit_update;

    always_comb begin
        ms_inc     = (r_ms != 16'hFFFF) ? r_ms + 1'b1 : r_ms;
        upd_value  = {i_frame.bytes[2], i_frame.bytes[1]};
        fits       = int'(i_frame.count) <= tprd_pkg::BUFFER_DEPTH;
        hit_button = (i_frame.count == {1'b0, i_cfg.button_length})
                     && (i_frame.bytes[0] == i_cfg.button_code);
        hit_coord  = (i_frame.count == {1'b0, i_cfg.coord_length})
                     && (i_frame.bytes[0] == i_cfg.coord_code);
        hit_update = (i_frame.count == {1'b0, i_cfg.update_length})
                     && (i_frame.bytes[0] == i_cfg.update_code);

        o_result  = '0;
        n_pressed = r_pressed;
        n_phase   = r_phase;
        n_x_latch = r_x_latch;
        n_ms      = r_ms;

        if (i_item.command == tprd_pkg::CMD_TICK) begin
            n_ms = ms_inc;
            if (r_pressed && (ms_inc > i_cfg.poll_period_ms)) begin
                if (r_phase == tprd_pkg::PH_REQ_X) begin
                    o_result.event_kind = tprd_pkg::EV_REQ_X;
                    n_phase = tprd_pkg::PH_X_SENT;
                end else if (r_phase == tprd_pkg::PH_REQ_Y) begin
                    o_result.event_kind = tprd_pkg::EV_REQ_Y;
                    n_phase = tprd_pkg::PH_Y_SENT;
                end
                n_ms = '0;
            end
        end else if (i_frame.done && fits) begin
            priority if (hit_button) begin
                o_result.event_kind    = tprd_pkg::EV_BUTTON;
                o_result.button_state  = i_frame.bytes[1];
                o_result.button_number = i_frame.bytes[2];
            end else if (hit_coord) begin
                o_result.event_kind = tprd_pkg::EV_COORD;
                o_result.x_pos      = {i_frame.bytes[1], i_frame.bytes[2]};
                o_result.y_pos      = {i_frame.bytes[3], i_frame.bytes[4]};
                if (i_frame.bytes[5] != 8'd0) begin
                    n_pressed           = 1'b1;
                    o_result.press_type = tprd_pkg::PRESS_INITIAL;
                    n_phase             = tprd_pkg::PH_REQ_X;
                end else begin
                    n_pressed           = 1'b0;
                    o_result.press_type = tprd_pkg::PRESS_NONE;
                end
            end else if (hit_update) begin
                if (r_phase == tprd_pkg::PH_X_SENT) begin
                    n_x_latch = upd_value;
                    n_phase   = tprd_pkg::PH_REQ_Y;
                end else if (r_phase == tprd_pkg::PH_Y_SENT) begin
                    n_phase = tprd_pkg::PH_REQ_X;
                    if (r_pressed) begin
                        o_result.event_kind = tprd_pkg::EV_COORD;
                        o_result.x_pos      = r_x_latch;
                        o_result.y_pos      = upd_value;
                        o_result.press_type = tprd_pkg::PRESS_HOLD;
                    end
                end
            end else begin
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pressed <= 1'b0;
            r_phase   <= tprd_pkg::PH_REQ_X;
            r_x_latch <= '0;
            r_ms      <= '0;
        end else if (i_advance) begin
            r_pressed <= n_pressed;
            r_phase   <= n_phase;
            r_x_latch <= n_x_latch;
            r_ms      <= n_ms;
        end
    end

endmodule

`default_nettype wire

### src/touch_panel_response_decoder.sv
// top level of the touch panel response decoder: input and result registers
// depends on tprd_pkg, tprd_cfg_regs, tprd_frame_buf, tprd_event_dec
// and touch_panel_response_decoder_assert.svh
//
// Each accepted item (a received panel byte or a one millisecond tick)
// gives exactly one result item via the input and result registers. An
// item is accepted every cycle while the output is not stalled: the
// input register feeds decode logic that updates the frame store, press
// state and poll timer and loads the result register, so sustained rate
// is one item per cycle. With the output stalled, one more item is held
// in the input register before o_in_stall rises. Configuration writes
// take effect at the next edge and belong only to idle periods.
`default_nettype none

module touch_panel_response_decoder (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_wr_en,
    input  wire logic [2:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  tprd_pkg::t_in_item     i_in_item,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output tprd_pkg::t_out_item    o_out_item
);

    tprd_pkg::t_cfg        cfg;
    tprd_pkg::t_frame_info frame;
    tprd_pkg::t_out_item   n_result;
    tprd_pkg::t_in_item    r_in_item;
    tprd_pkg::t_out_item   r_out_item;
    logic                  r_in_valid;
    logic                  r_out_valid;
    logic                  advance;

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && r_out_valid && i_out_stall;

    tprd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    tprd_frame_buf u_frame_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_frame   (frame)
    );

    tprd_event_dec u_event_dec (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .i_frame   (frame),
        .i_cfg     (cfg),
        .o_result  (n_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_item <= i_in_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= n_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

`include "touch_panel_response_decoder_assert.svh"

    `TPRD_ASSERT(a_stall_only_when_full, o_in_stall |-> (r_in_valid && r_out_valid))
    `TPRD_ASSERT_NEXT(a_result_kept, r_out_valid && i_out_stall, r_out_valid)
    `TPRD_ASSERT(a_button_fields_clean, (o_out_valid && (o_out_item.event_kind == tprd_pkg::EV_BUTTON)) |-> ((o_out_item.x_pos == 16'd0) && (o_out_item.y_pos == 16'd0) && (o_out_item.press_type == tprd_pkg::PRESS_NONE)))
    `TPRD_ASSERT(a_press_only_on_coord, (o_out_valid && (o_out_item.press_type != tprd_pkg::PRESS_NONE)) |-> (o_out_item.event_kind == tprd_pkg::EV_COORD))

endmodule

`default_nettype wire

### verif/tprd_tb_pkg.sv
`timescale 1ns / 100ps
// scoreboard class for the touch panel response decoder testbench: predicts
// the result item of every accepted item and checks results in order
// depends on tprd_pkg
package tprd_tb_pkg;
    import tprd_pkg::*;

    class tprd_event_scoreboard;
        t_cfg        regs;
        logic [7:0]  frame_bytes [BUFFER_DEPTH];
        logic [5:0]  frame_len;
        logic [1:0]  ff_run;
        logic        pressed;
        t_poll_phase phase;
        logic [15:0] x_held;
        logic [15:0] ms_elapsed;
        t_out_item   pending_events [$];
        int          errors;
        int          n_checked;
        int          kind_count [5];

        function new();
            regs.button_code    = RST_BUTTON_CODE;
            regs.button_length  = RST_BUTTON_LENGTH;
            regs.coord_code     = RST_COORD_CODE;
            regs.coord_length   = RST_COORD_LENGTH;
            regs.update_code    = RST_UPDATE_CODE;
            regs.update_length  = RST_UPDATE_LENGTH;
            regs.poll_period_ms = RST_POLL_PERIOD;
            foreach (frame_bytes[i]) frame_bytes[i] = '0;
            frame_len  = '0;
            ff_run     = '0;
            pressed    = 1'b0;
            phase      = PH_REQ_X;
            x_held     = '0;
            ms_elapsed = '0;
            errors     = 0;
            n_checked  = 0;
            foreach (kind_count[i]) kind_count[i] = 0;
        endfunction

        function void set_reg(t_cfg_index idx, logic [15:0] v);
            case (idx)
                CFG_BUTTON_CODE:   regs.button_code    = v[7:0];
                CFG_BUTTON_LENGTH: regs.button_length  = v[4:0];
                CFG_COORD_CODE:    regs.coord_code     = v[7:0];
                CFG_COORD_LENGTH:  regs.coord_length   = v[4:0];
                CFG_UPDATE_CODE:   regs.update_code    = v[7:0];
                CFG_UPDATE_LENGTH: regs.update_length  = v[4:0];
                CFG_POLL_PERIOD:   regs.poll_period_ms = v;
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_events.size();
        endfunction

        // match order: button, press/release, polled value
        function t_out_item decode_frame();
            t_out_item   r;
            logic [7:0]  lead;
            logic [15:0] v;
            r    = '0;
            lead = frame_bytes[0];
            if (frame_len > BUFFER_DEPTH)
                return r;
            if (frame_len == regs.button_length && lead == regs.button_code) begin
                r.event_kind    = EV_BUTTON;
                r.button_state  = frame_bytes[1];
                r.button_number = frame_bytes[2];
            end else if (frame_len == regs.coord_length && lead == regs.coord_code) begin
                r.event_kind = EV_COORD;
                r.x_pos      = {frame_bytes[1], frame_bytes[2]};
                r.y_pos      = {frame_bytes[3], frame_bytes[4]};
                if (frame_bytes[5] != 8'h00) begin
                    pressed      = 1'b1;
                    r.press_type = PRESS_INITIAL;
                    phase        = PH_REQ_X;
                end else begin
                    pressed      = 1'b0;
                    r.press_type = PRESS_NONE;
                end
            end else if (frame_len == regs.update_length && lead == regs.update_code) begin
                v = {frame_bytes[2], frame_bytes[1]};
                if (phase == PH_X_SENT) begin
                    x_held = v;
                    phase  = PH_REQ_Y;
                end else if (phase == PH_Y_SENT) begin
                    phase = PH_REQ_X;
                    if (pressed) begin
                        r.event_kind = EV_COORD;
                        r.x_pos      = x_held;
                        r.y_pos      = v;
                        r.press_type = PRESS_HOLD;
                    end
                end
            end
            return r;
        endfunction

        function void note_item(t_in_item it);
            t_out_item r;
            r = '0;
            if (it.command == CMD_TICK) begin
                if (ms_elapsed != 16'hFFFF)
                    ms_elapsed = ms_elapsed + 16'd1;
                if (pressed && ms_elapsed > regs.poll_period_ms) begin
                    if (phase == PH_REQ_X) begin
                        r.event_kind = EV_REQ_X;
                        phase        = PH_X_SENT;
                    end else if (phase == PH_REQ_Y) begin
                        r.event_kind = EV_REQ_Y;
                        phase        = PH_Y_SENT;
                    end
                    ms_elapsed = '0;
                end
            end else begin
                if (frame_len < BUFFER_DEPTH)
                    frame_bytes[frame_len] = it.rx_byte;
                if (frame_len != COUNT_MAX)
                    frame_len = frame_len + 6'd1;
                ff_run = (it.rx_byte == TERM_BYTE) ? ff_run + 2'd1 : 2'd0;
                if (ff_run == TERM_RUN) begin
                    ff_run    = '0;
                    r         = decode_frame();
                    frame_len = '0;
                end
            end
            if (r.event_kind < 5)
                kind_count[r.event_kind]++;
            pending_events.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: %s mismatch, expected %0h, actual %0h",
                             $time, name, want, got);
            end
        endfunction

        function void check_event(t_out_item got);
            t_out_item want;
            if (pending_events.size() == 0) begin
                errors++;
                if (errors <= 100)
                    $display("%0t: result item with none expected, expected nothing, actual %h",
                             $time, got);
                return;
            end
            want = pending_events.pop_front();
            n_checked++;
            compare_field("event_kind", want.event_kind, got.event_kind);
            compare_field("button_state", want.button_state, got.button_state);
            compare_field("button_number", want.button_number, got.button_number);
            compare_field("x_pos", want.x_pos, got.x_pos);
            compare_field("y_pos", want.y_pos, got.y_pos);
            compare_field("press_type", want.press_type, got.press_type);
        endfunction

        function void final_check();
            if (pending_events.size() != 0) begin
                errors++;
                $display("%0t: %0d result items never arrived", $time, pending_events.size());
            end
        endfunction
    endclass

endpackage

### verif/touch_panel_response_decoder_tb.sv
`timescale 1ns / 100ps
// testbench top for touch_panel_response_decoder: drives bytes, ticks and
// register writes with random idling and checks every result item
// depends on tprd_pkg, tprd_tb_pkg and the decoder rtl
module touch_panel_response_decoder_tb;
    import tprd_pkg::*;
    import tprd_tb_pkg::*;

    localparam int LONG_HOLD         = 40;
    localparam int QUIET_LIMIT       = 1000;
    localparam int LONG_PERIOD_TICKS = 20;

    typedef enum {KIND_BUTTON, KIND_COORD, KIND_UPDATE} t_frame_kind;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_wr_en = 1'b0;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data  = '0;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    t_in_item    i_in_item   = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    t_out_item   o_out_item;

    tprd_event_scoreboard sb = new();

    bit idling       = 1'b0;
    bit quiet_tail   = 1'b0;
    bit hold_request = 1'b0;
    int n_sent       = 0;
    int quiet        = 0;

    touch_panel_response_decoder uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                sb.note_item(i_in_item);
            if (o_out_valid && !i_out_stall)
                sb.check_event(o_out_item);
        end
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_LIMIT) begin
            $display("%0t: timeout, nothing accepted for %0d cycles", $time, quiet);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // result side: short random stalls, or one long hold-off on request
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                hold_request = 1'b0;
                i_out_stall <= 1'b1;
                repeat (LONG_HOLD) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else if (idling && $urandom_range(0, 7) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic gap(input int n);
        repeat (n) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
        end
    endtask

    task automatic push(input logic cmd, input logic [7:0] b);
        t_in_item it;
        it.command = cmd;
        it.rx_byte = b;
        if (idling && $urandom_range(0, 9) == 0)
            gap($urandom_range(1, 3));
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        do @(posedge i_clk); while (o_in_stall);
        n_sent++;
    endtask

    task automatic send_ticks(input int n);
        repeat (n) push(CMD_TICK, 8'($urandom));
    endtask

    task automatic send_byte(input logic [7:0] b);
        push(CMD_BYTE, b);
    endtask

    task automatic resync();
        send_byte(8'h00);
        repeat (3) send_byte(TERM_BYTE);
    endtask

    // ticks may land inside a frame
    task automatic send_body(input logic [7:0] body [$]);
        foreach (body[i]) begin
            if ($urandom_range(0, 11) == 0)
                send_ticks(1);
            send_byte(body[i]);
        end
        repeat (3) send_byte(TERM_BYTE);
    endtask

    // keep a body from ending its own frame early
    function automatic void clean_runs(ref logic [7:0] body [$]);
        for (int i = 2; i < body.size(); i++)
            if (body[i] == TERM_BYTE && body[i-1] == TERM_BYTE && body[i-2] == TERM_BYTE)
                body[i] = 8'hFE;
        if (body.size() > 1 && body[body.size()-1] == TERM_BYTE)
            body[body.size()-1] = 8'hFE;
    endfunction

    function automatic logic [7:0] kind_code(input t_frame_kind k);
        case (k)
            KIND_BUTTON: return sb.regs.button_code;
            KIND_COORD:  return sb.regs.coord_code;
            default:     return sb.regs.update_code;
        endcase
    endfunction

    function automatic int kind_len(input t_frame_kind k);
        case (k)
            KIND_BUTTON: return int'(sb.regs.button_length);
            KIND_COORD:  return int'(sb.regs.coord_length);
            default:     return int'(sb.regs.update_length);
        endcase
    endfunction

    // fld[0] is the byte after the code
    task automatic send_frame(input t_frame_kind kind, input int len_delta,
                              input logic [4:0][7:0] fld);
        logic [7:0] body [$];
        int         n;
        n = kind_len(kind) + len_delta - 3;
        if (n < 1)
            n = 1;
        body.push_back(kind_code(kind));
        for (int i = 1; i < n; i++)
            body.push_back((i <= 5) ? fld[i-1] : 8'($urandom));
        clean_runs(body);
        send_body(body);
    endtask

    task automatic send_overflow();
        logic [7:0] body [$];
        int         n;
        n = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 70) : $urandom_range(13, 22);
        body.push_back(kind_code(t_frame_kind'($urandom_range(0, 2))));
        for (int i = 1; i < n; i++)
            body.push_back(8'($urandom));
        clean_runs(body);
        send_body(body);
    endtask

    task automatic send_noise();
        int n;
        n = $urandom_range(1, 24);
        repeat (n)
            send_byte(($urandom_range(0, 2) == 0) ? TERM_BYTE : 8'($urandom));
        resync();
    endtask

    function automatic logic [4:0][7:0] rand_fields();
        return {8'($urandom), 32'($urandom)};
    endfunction

    // ask x, answer x, ask y, sometimes release, answer y
    task automatic poll_round();
        logic [4:0][7:0] f;
        int              p;
        p = int'(sb.regs.poll_period_ms);
        if (p > 40)
            p = $urandom_range(0, 5);
        send_ticks(p + 1);
        send_frame(KIND_UPDATE, 0, rand_fields());
        send_ticks(p + 1);
        if ($urandom_range(0, 4) == 0) begin
            f    = rand_fields();
            f[4] = 8'h00;
            send_frame(KIND_COORD, 0, f);
        end
        send_frame(KIND_UPDATE, 0, rand_fields());
    endtask

    task automatic random_transaction();
        logic [4:0][7:0] f;
        int              r;
        r      = $urandom_range(0, 99);
        f      = rand_fields();
        idling = !quiet_tail && ($urandom_range(0, 3) != 0);
        if (r < 14) begin
            send_frame(KIND_BUTTON, 0, f);
        end else if (r < 28) begin
            if (f[4] == 8'h00)
                f[4] = 8'h01;
            send_frame(KIND_COORD, 0, f);
        end else if (r < 34) begin
            f[4] = 8'h00;
            send_frame(KIND_COORD, 0, f);
        end else if (r < 56) begin
            poll_round();
        end else if (r < 64) begin
            send_ticks($urandom_range(1, 12));
        end else if (r < 72) begin
            send_frame(KIND_UPDATE, 0, f);
        end else if (r < 82) begin
            send_noise();
        end else if (r < 90) begin
            send_overflow();
        end else begin
            send_frame(t_frame_kind'($urandom_range(0, 2)),
                       ($urandom_range(0, 1) == 0) ? -$urandom_range(1, 2)
                                                   : $urandom_range(1, 2), f);
        end
    endtask

    task automatic run_phase(input int count);
        int stop_at;
        stop_at = n_sent + count;
        while (n_sent < stop_at)
            random_transaction();
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_index idx, input logic [15:0] v);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= v;
        @(posedge i_clk);
        sb.set_reg(idx, v);
    endtask

    task automatic configure(input logic [15:0] bc, input logic [15:0] bl,
                             input logic [15:0] cc, input logic [15:0] cl,
                             input logic [15:0] uc, input logic [15:0] ul,
                             input logic [15:0] pp);
        drain();
        write_reg(CFG_BUTTON_CODE, bc);
        write_reg(CFG_BUTTON_LENGTH, bl);
        write_reg(CFG_COORD_CODE, cc);
        write_reg(CFG_COORD_LENGTH, cl);
        write_reg(CFG_UPDATE_CODE, uc);
        write_reg(CFG_UPDATE_LENGTH, ul);
        write_reg(CFG_POLL_PERIOD, pp);
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
    endtask

    // long result hold-off while items keep coming
    task automatic backpressure_burst();
        idling       = 1'b0;
        hold_request = 1'b1;
        repeat (4) send_frame(KIND_BUTTON, 0, rand_fields());
    endtask

    initial begin
        logic [4:0][7:0] f;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // press at x ffff y 0000 fills store positions 0..8 first
        send_frame(KIND_COORD, 0, {8'h01, 8'h00, 8'h00, 8'hFF, 8'hFF});
        send_ticks(6);
        send_frame(KIND_BUTTON, 0, {8'h00, 8'h00, 8'h00, 8'hFF, 8'h00});

        run_phase(250);
        backpressure_burst();
        drain();
        run_phase(60);

        configure(16'd0, 16'd16, 16'd255, 16'd16, 16'd128, 16'd4, 16'd0);
        run_phase(250);

        // identical codes and lengths: button wins
        configure(16'h42, 16'd9, 16'h42, 16'd9, 16'h42, 16'd9, 16'd3);
        run_phase(120);

        repeat (2) begin
            configure(16'($urandom_range(0, 255)), 16'($urandom_range(4, 16)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(4, 16)),
                      16'($urandom_range(0, 255)), 16'($urandom_range(4, 16)),
                      16'($urandom_range(0, 12)));
            run_phase(250);
        end

        configure(16'd255, 16'd1, 16'd0, 16'd3, 16'd255, 16'd16, 16'd1);
        run_phase(150);

        // very long poll periods: pressed, but no poll falls due
        configure(16'(RST_BUTTON_CODE), 16'(RST_BUTTON_LENGTH), 16'(RST_COORD_CODE),
                  16'(RST_COORD_LENGTH), 16'(RST_UPDATE_CODE), 16'(RST_UPDATE_LENGTH),
                  16'hFFFF);
        idling = 1'b0;
        f      = rand_fields();
        f[4]   = 8'h80;
        send_frame(KIND_COORD, 0, f);
        send_ticks(LONG_PERIOD_TICKS);
        configure(16'(RST_BUTTON_CODE), 16'(RST_BUTTON_LENGTH), 16'(RST_COORD_CODE),
                  16'(RST_COORD_LENGTH), 16'(RST_UPDATE_CODE), 16'(RST_UPDATE_LENGTH),
                  16'hFFFE);
        send_ticks(1);

        configure(16'(RST_BUTTON_CODE), 16'(RST_BUTTON_LENGTH), 16'(RST_COORD_CODE),
                  16'(RST_COORD_LENGTH), 16'(RST_UPDATE_CODE), 16'(RST_UPDATE_LENGTH),
                  RST_POLL_PERIOD);
        quiet_tail = 1'b1;
        run_phase(300);
        drain();
        repeat (10) @(posedge i_clk);

        sb.final_check();
        $display("run covered %0d items and %0d results", n_sent, sb.n_checked);
        $display("  %0d button, %0d coordinate, %0d x poll, %0d y poll",
                 sb.kind_count[EV_BUTTON], sb.kind_count[EV_COORD],
                 sb.kind_count[EV_REQ_X], sb.kind_count[EV_REQ_Y]);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
